// ----- rtl/core/ws2i_pkg.sv -----
`default_nettype none

package ws2i_pkg;

    // Position counter width; the reported offset is also clamped to 16 bits.
    localparam int OFFSET_BITS = 16;

    localparam int CH_W      = 16;
    localparam int BASE_W    = 6;
    localparam int ACC_W     = 33;
    localparam int VALUE_W   = 32;
    localparam int END_W     = 16;
    localparam int NUM_ZERO  = 18;
    localparam int NUM_SPACE = 26;

    typedef logic [CH_W-1:0]   t_char;
    typedef logic [BASE_W-1:0] t_base;

    localparam t_base NO_DIGIT   = 6'd63;
    localparam t_base BASE_RESET = 6'd10;
    localparam t_base BASE_AUTO  = 6'd0;
    localparam t_base BASE_OCT   = 6'd8;
    localparam t_base BASE_DEC   = 6'd10;
    localparam t_base BASE_HEX   = 6'd16;
    localparam t_base BASE_MIN   = 6'd2;
    localparam t_base BASE_MAX   = 6'd36;

    localparam t_char CH_PLUS  = 16'h002B;
    localparam t_char CH_MINUS = 16'h002D;
    localparam t_char CH_LX    = 16'h0078;
    localparam t_char CH_UX    = 16'h0058;
    localparam t_char CH_LA    = 16'h0061;
    localparam t_char CH_LZ    = 16'h007A;
    localparam t_char CH_UA    = 16'h0041;
    localparam t_char CH_UZ    = 16'h005A;

    localparam logic [ACC_W-1:0] ACC_CAP = 33'h1_0000_0000;

    // Zero code of each decimal digit block.
    localparam t_char DIGIT_ZERO [NUM_ZERO] = '{
        16'h0030, 16'h0660, 16'h06F0, 16'h0966, 16'h09E6, 16'h0A66,
        16'h0AE6, 16'h0B66, 16'h0C66, 16'h0CE6, 16'h0D66, 16'h0E50,
        16'h0ED0, 16'h0F20, 16'h1040, 16'h17E0, 16'h1810, 16'hFF10
    };

    localparam t_char SPACE_CODE [NUM_SPACE] = '{
        16'h0009, 16'h000A, 16'h000B, 16'h000C, 16'h000D, 16'h0020,
        16'h0085, 16'h00A0, 16'h1680, 16'h180E, 16'h2000, 16'h2001,
        16'h2002, 16'h2003, 16'h2004, 16'h2005, 16'h2006, 16'h2007,
        16'h2008, 16'h2009, 16'h200A, 16'h2028, 16'h2029, 16'h202F,
        16'h205F, 16'h3000
    };

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_AFTERX,
        PH_DIGITS
    } t_phase;

    typedef struct packed {
        logic  is_space;
        logic  is_plus;
        logic  is_minus;
        logic  is_x;
        t_base digit;
    } t_char_class;

endpackage

`default_nettype wire

// ----- rtl/core/wide_string_to_int32_parser.sv -----
`default_nettype none

// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+--------------------------------------
// in       | sink      | i_in_valid / o_in_ready | i_ch, i_start_req
// out      | source    | o_out_valid/i_out_ready | o_value, o_end_offset, o_range_error,
//          |           |                         | o_bad_base
// config   | APB slave | psel/penable/pready     | paddr, pwrite, pwdata, prdata
//
// One character per cycle sustained while the output is not stalled. A character
// is captured in the input register, then decoded and folded into the conversion
// state (one 33x6 multiply-add) when it is processed, and any result lands in the
// output register at the same edge as the state update. Reset clears the state to
// idle and the configured base to 10. A stalled output register holds the
// processing stage, and the input register then fills and drops ready.

module wide_string_to_int32_parser (
    input  wire                       i_clk,
    input  wire                       i_rst_n,

    input  wire                       i_in_valid,
    output logic                      o_in_ready,
    input  ws2i_pkg::t_char           i_ch,
    input  wire                       i_start_req,

    output logic                      o_out_valid,
    input  wire                       i_out_ready,
    output logic signed [31:0]        o_value,
    output logic [15:0]               o_end_offset,
    output logic                      o_range_error,
    output logic                      o_bad_base,

    input  wire                       psel,
    input  wire                       penable,
    input  wire                       pwrite,
    input  wire  [2:0]                paddr,
    input  wire  [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import ws2i_pkg::*;

    localparam logic REG_NUMBER_BASE = 1'b0;

    // Configuration
    t_base r_cfg_base;

    // Input register
    logic  r_in_valid;
    t_char r_in_ch;
    logic  r_in_start;

    // Conversion state
    t_phase                 r_phase, n_phase;
    logic                   r_neg, n_neg;
    t_base                  r_base, n_base;
    logic [ACC_W-1:0]       r_acc, n_acc;
    logic                   r_ovf, n_ovf;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;

    // Result register
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_value;
    logic [END_W-1:0]   r_end;
    logic               r_rng;
    logic               r_bad;

    t_char_class cls;
    logic        fire;
    logic        res_valid;
    logic [VALUE_W-1:0] res_value;
    logic [END_W-1:0]   res_end;
    logic               res_rng;
    logic               res_bad;

    ws2i_char_class u_class (
        .i_ch    (r_in_ch),
        .o_class (cls)
    );

    // Process the held character whenever the result slot is free or draining.
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    // APB: zero-wait, only word 0 exists.
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_NUMBER_BASE) begin
            prdata = 32'(r_cfg_base);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base <= BASE_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_NUMBER_BASE) begin
            r_cfg_base <= pwdata[BASE_W-1:0];
        end
    end

    // Next-state and result logic for one character.
    always_comb begin
        t_phase             cur;
        logic               first_digit;
        logic               do_acc;
        logic               do_adv;
        logic               emit_acc;
        logic               emit_zero;
        logic [ACC_W+BASE_W-1:0] prod;
        logic [ACC_W-1:0]   mag;
        logic [OFFSET_BITS-1:0] off;
        logic [31:0]        off_w;
        logic [ACC_W-1:0]   limit;

        n_phase     = r_phase;
        n_neg       = r_neg;
        n_base      = r_base;
        n_acc       = r_acc;
        n_ovf       = r_ovf;
        n_pos       = r_pos;
        cur         = r_phase;
        first_digit = 1'b0;
        do_acc      = 1'b0;
        do_adv      = 1'b0;
        emit_acc    = 1'b0;
        emit_zero   = 1'b0;
        res_bad     = 1'b0;
        prod        = '0;

        // Start: reload the state, sample the base and flag a base that is out of range.
        if (r_in_start) begin
            n_neg  = 1'b0;
            n_acc  = '0;
            n_ovf  = 1'b0;
            n_pos  = '0;
            n_base = r_cfg_base;
            if (r_cfg_base != BASE_AUTO
                && (r_cfg_base < BASE_MIN || r_cfg_base > BASE_MAX)) begin
                res_bad = 1'b1;
                cur     = PH_IDLE;
                n_phase = PH_IDLE;
            end else begin
                cur     = PH_SPACE;
                n_phase = PH_SPACE;
            end
        end

        case (cur)
            PH_SPACE: begin
                if (cls.is_space) begin
                    do_adv = 1'b1;
                end else if (cls.is_plus || cls.is_minus) begin
                    n_neg   = cls.is_minus;
                    do_adv  = 1'b1;
                    n_phase = PH_SIGNED;
                end else begin
                    first_digit = 1'b1;
                end
            end
            PH_SIGNED: begin
                first_digit = 1'b1;
            end
            PH_ZERO: begin
                if (cls.is_x) begin
                    n_base  = BASE_HEX;
                    do_adv  = 1'b1;
                    n_phase = PH_AFTERX;
                end else begin
                    if (n_base == BASE_AUTO) begin
                        n_base = BASE_OCT;
                    end
                    if (cls.digit < n_base) begin
                        do_acc = 1'b1;
                    end else begin
                        emit_acc = 1'b1;
                    end
                end
            end
            PH_AFTERX: begin
                if (cls.digit < n_base) begin
                    do_acc = 1'b1;
                end else begin
                    emit_zero = 1'b1;
                end
            end
            PH_DIGITS: begin
                if (cls.digit < n_base) begin
                    do_acc = 1'b1;
                end else begin
                    emit_acc = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // First possible digit: a leading zero may open a prefix.
        if (first_digit) begin
            if ((n_base == BASE_AUTO || n_base == BASE_HEX) && cls.digit == '0) begin
                n_acc   = '0;
                do_adv  = 1'b1;
                n_phase = PH_ZERO;
            end else begin
                if (n_base == BASE_AUTO) begin
                    n_base = BASE_DEC;
                end
                if (cls.digit < n_base) begin
                    do_acc = 1'b1;
                end else begin
                    emit_zero = 1'b1;
                end
            end
        end

        // Multiply-add, saturating at the cap.
        if (do_acc) begin
            if (!n_ovf) begin
                prod = {{BASE_W{1'b0}}, n_acc} * {{ACC_W{1'b0}}, n_base}
                     + (ACC_W+BASE_W)'(cls.digit);
                if (prod > (ACC_W+BASE_W)'(ACC_CAP)) begin
                    n_acc = ACC_CAP;
                    n_ovf = 1'b1;
                end else begin
                    n_acc = prod[ACC_W-1:0];
                end
            end
            do_adv  = 1'b1;
            n_phase = PH_DIGITS;
        end

        if (do_adv && n_pos != {OFFSET_BITS{1'b1}}) begin
            n_pos = n_pos + OFFSET_BITS'(1);
        end

        if (emit_acc || emit_zero) begin
            n_phase = PH_IDLE;
        end

        // Clamp the magnitude to the signed range.
        mag   = emit_acc ? n_acc : '0;
        off   = emit_acc ? n_pos : '0;
        limit = n_neg ? ACC_W'(33'h0_8000_0000) : ACC_W'(33'h0_7FFF_FFFF);
        res_rng = mag > limit;
        if (res_rng) begin
            res_value = n_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            res_value = n_neg ? (32'd0 - mag[VALUE_W-1:0]) : mag[VALUE_W-1:0];
        end
        off_w   = 32'(off);
        res_end = (off_w > 32'h0000_FFFF) ? 16'hFFFF : off_w[END_W-1:0];

        if (res_bad) begin
            res_value = '0;
            res_end   = '0;
            res_rng   = 1'b0;
        end

        res_valid = emit_acc || emit_zero || res_bad;
    end

    // Input register: hold until processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_ch    <= i_ch;
            r_in_start <= i_start_req;
        end
    end

    // Conversion state: advance on each processed character.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_neg   <= 1'b0;
            r_base  <= '0;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
            r_pos   <= '0;
        end else if (fire) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_base  <= n_base;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
            r_pos   <= n_pos;
        end
    end

    // Result register: load on emit, drop after transfer out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res_valid) begin
            r_value <= res_value;
            r_end   <= res_end;
            r_rng   <= res_rng;
            r_bad   <= res_bad;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_value       = r_value;
    assign o_end_offset  = r_end;
    assign o_range_error = r_rng;
    assign o_bad_base    = r_bad;

endmodule

`default_nettype wire

// ----- rtl/core/ws2i_char_class.sv -----
`default_nettype none

module ws2i_char_class (
    input  ws2i_pkg::t_char       i_ch,
    output ws2i_pkg::t_char_class o_class
);
    import ws2i_pkg::*;

    always_comb begin
        t_char diff;
        o_class.is_space = 1'b0;
        o_class.is_plus  = (i_ch == CH_PLUS);
        o_class.is_minus = (i_ch == CH_MINUS);
        o_class.is_x     = (i_ch == CH_LX) || (i_ch == CH_UX);
        o_class.digit    = NO_DIGIT;
        diff             = '0;

        for (int i = 0; i < NUM_SPACE; i++) begin
            if (i_ch == SPACE_CODE[i]) begin
                o_class.is_space = 1'b1;
            end
        end

        if (i_ch >= CH_LA && i_ch <= CH_LZ) begin
            o_class.digit = BASE_W'(i_ch - CH_LA) + BASE_W'(10);
        end else if (i_ch >= CH_UA && i_ch <= CH_UZ) begin
            o_class.digit = BASE_W'(i_ch - CH_UA) + BASE_W'(10);
        end

        // Walk down so the lowest matching block wins.
        for (int i = NUM_ZERO - 1; i >= 0; i--) begin
            diff = i_ch - DIGIT_ZERO[i];
            if (diff <= t_char'(9)) begin
                o_class.digit = BASE_W'(diff);
            end
        end
    end

endmodule

`default_nettype wire
